// ----- design/plsa_pkg.sv -----
// plsa_pkg: shared constants, register map and latency for the point lens source address block
// no dependencies; imported by the top level, the pipelined divider, the port checker and the bench
`default_nettype none

package plsa_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int K_BITS         = 16;
    localparam int DATA_BITS      = 32;
    localparam int REG_IDX_BITS   = 3;
    localparam int ADDR_BITS      = REG_IDX_BITS + 2;

    localparam int CENTER_X_RST    = 45;
    localparam int CENTER_Y_RST    = 50;
    localparam int LENS_K_RST      = 100;
    localparam int LAST_COLUMN_RST = 99;
    localparam int LAST_ROW_RST    = 99;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_LENS_K      = 3'd2,
        REG_LAST_COLUMN = 3'd3,
        REG_LAST_ROW    = 3'd4
    } t_reg_idx;

    // clock edges from the accepting edge to the edge that takes the result
    function automatic int plsa_latency(input int coord_bits);
        return coord_bits + 7;
    endfunction

endpackage

`default_nettype wire

// ----- design/plsa_div.sv -----
// plsa_div: pipelined restoring divider, one quotient bit per register stage
// uses plsa_pkg; instantiated twice by point_lens_source_address
`default_nettype none

module plsa_div
    import plsa_pkg::*;
#(
    parameter int NUM_W = 33,
    parameter int DEN_W = 22,
    parameter int QUO_W = COORD_BITS_DEF + 1
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [CW-1:0]    r_rem [0:QUO_W-1];
    logic [DEN_W-1:0] r_den [0:QUO_W-1];
    logic [QUO_W-1:0] r_quo [0:QUO_W-1];

    genvar s;
    generate
        for (s = 0; s < QUO_W; s++) begin : g_stage
            localparam int BIT = QUO_W - 1 - s;
            logic [CW-1:0]    w_rem_in;
            logic [CW-1:0]    w_trial;
            logic [DEN_W-1:0] w_den_in;
            logic [QUO_W-1:0] w_quo_in;
            logic             w_ge;

            if (s == 0) begin : g_first
                assign w_rem_in = CW'(i_num);
                assign w_den_in = i_den;
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[s-1];
                assign w_den_in = r_den[s-1];
                assign w_quo_in = r_quo[s-1];
            end

            assign w_trial = CW'(w_den_in) << BIT;
            assign w_ge    = (w_rem_in >= w_trial);

            always_ff @(posedge i_clk) begin
                r_rem[s] <= w_ge ? (w_rem_in - w_trial) : w_rem_in;
                r_den[s] <= w_den_in;
                r_quo[s] <= w_quo_in | (QUO_W'(w_ge) << BIT);
            end
        end
    endgenerate

    assign o_quo = r_quo[QUO_W-1];

endmodule

`default_nettype wire

// ----- design/point_lens_source_address.sv -----
// point_lens_source_address: source pixel address under a point-mass lens, one pixel per clock
// uses plsa_pkg and two plsa_div instances
//
// usage
//   request channel: drive i_pixel_column / i_pixel_row with start high; a request is taken
//   at every rising edge with start high and busy low. busy is always low, so a new pixel
//   can be issued on every clock.
//   result channel: o_done is high for exactly one cycle per request, with o_source_column,
//   o_source_row, o_inside_res and o_at_center valid in that cycle. the receiver cannot
//   stall; results come in request order.
//   config: APB-style write/read of center_x (0x00), center_y (0x04), lens_strength (0x08),
//   last_column (0x0C), last_row (0x10); pready is always high. write only while no request
//   is in flight.
// pipeline / throughput
//   five arithmetic stages (offsets, r2, r2 - K, products, rounding numerator),
//   COORD_BITS + 1 divider stages for the two quotients in parallel, and the output
//   register. one request per clock sustained.
// reset
//   i_rst_n low clears all in-flight requests and loads the register defaults.
`default_nettype none

module point_lens_source_address
    import plsa_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_pixel_column,
    input  logic [COORD_BITS-1:0] i_pixel_row,
    output logic                  o_done,
    output logic [COORD_BITS-1:0] o_source_column,
    output logic [COORD_BITS-1:0] o_source_row,
    output logic                  o_inside_res,
    output logic                  o_at_center,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready
);

    localparam int CB  = COORD_BITS;
    localparam int RW  = 2 * CB + 1;
    localparam int FMW = (RW > K_BITS) ? RW : K_BITS;
    localparam int FW  = FMW + 1;
    localparam int MW  = CB + FMW;
    localparam int NW  = ((MW + 1 > RW) ? MW + 1 : RW) + 1;
    localparam int DW  = RW + 1;
    localparam int QB  = CB + 1;
    localparam int CW  = (NW > DW + QB) ? NW : DW + QB;
    localparam int SW  = CB + 3;
    localparam int SBW = 2 * CB + 5;

    // configuration registers
    logic [CB-1:0]     r_center_x;
    logic [CB-1:0]     r_center_y;
    logic [K_BITS-1:0] r_lens_k;
    logic [CB-1:0]     r_last_column;
    logic [CB-1:0]     r_last_row;
    logic              w_cfg_wr;
    t_reg_idx          w_reg_idx;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_reg_idx = t_reg_idx'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= CB'(CENTER_X_RST);
            r_center_y    <= CB'(CENTER_Y_RST);
            r_lens_k      <= K_BITS'(LENS_K_RST);
            r_last_column <= CB'(LAST_COLUMN_RST);
            r_last_row    <= CB'(LAST_ROW_RST);
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_CENTER_X:    r_center_x    <= pwdata[CB-1:0];
                REG_CENTER_Y:    r_center_y    <= pwdata[CB-1:0];
                REG_LENS_K:      r_lens_k      <= pwdata[K_BITS-1:0];
                REG_LAST_COLUMN: r_last_column <= pwdata[CB-1:0];
                REG_LAST_ROW:    r_last_row    <= pwdata[CB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_CENTER_X:    prdata = DATA_BITS'(r_center_x);
            REG_CENTER_Y:    prdata = DATA_BITS'(r_center_y);
            REG_LENS_K:      prdata = DATA_BITS'(r_lens_k);
            REG_LAST_COLUMN: prdata = DATA_BITS'(r_last_column);
            REG_LAST_ROW:    prdata = DATA_BITS'(r_last_row);
            default:         prdata = '0;
        endcase
    end

    // stage 1: signed offsets from the center, as sign and magnitude
    logic [CB:0]   w_dx;
    logic [CB:0]   w_dy;
    logic [CB:0]   w_dx_neg;
    logic [CB:0]   w_dy_neg;
    logic          r1_v;
    logic [CB-1:0] r1_px;
    logic [CB-1:0] r1_py;
    logic [CB-1:0] r1_adx;
    logic [CB-1:0] r1_ady;
    logic          r1_sdx;
    logic          r1_sdy;

    assign w_dx     = {1'b0, i_pixel_column} - {1'b0, r_center_x};
    assign w_dy     = {1'b0, r_center_y} - {1'b0, i_pixel_row};
    assign w_dx_neg = -w_dx;
    assign w_dy_neg = -w_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_px  <= i_pixel_column;
        r1_py  <= i_pixel_row;
        r1_sdx <= w_dx[CB];
        r1_sdy <= w_dy[CB];
        r1_adx <= w_dx[CB] ? w_dx_neg[CB-1:0] : w_dx[CB-1:0];
        r1_ady <= w_dy[CB] ? w_dy_neg[CB-1:0] : w_dy[CB-1:0];
    end

    // stage 2: squared radius
    logic [RW-1:0] w_ax2;
    logic [RW-1:0] w_ay2;
    logic          r2_v;
    logic [RW-1:0] r2_r2;
    logic [CB-1:0] r2_px;
    logic [CB-1:0] r2_py;
    logic [CB-1:0] r2_adx;
    logic [CB-1:0] r2_ady;
    logic          r2_sdx;
    logic          r2_sdy;

    assign w_ax2 = RW'(r1_adx);
    assign w_ay2 = RW'(r1_ady);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_r2  <= (w_ax2 * w_ax2) + (w_ay2 * w_ay2);
        r2_px  <= r1_px;
        r2_py  <= r1_py;
        r2_adx <= r1_adx;
        r2_ady <= r1_ady;
        r2_sdx <= r1_sdx;
        r2_sdy <= r1_sdy;
    end

    // stage 3: lens factor r2 - K, as sign and magnitude
    logic [FW-1:0]  w_f;
    logic [FW-1:0]  w_f_neg;
    logic           r3_v;
    logic [FMW-1:0] r3_fmag;
    logic           r3_sf;
    logic           r3_center;
    logic [RW-1:0]  r3_r2;
    logic [CB-1:0]  r3_px;
    logic [CB-1:0]  r3_py;
    logic [CB-1:0]  r3_adx;
    logic [CB-1:0]  r3_ady;
    logic           r3_sdx;
    logic           r3_sdy;

    assign w_f     = FW'(r2_r2) - FW'(r_lens_k);
    assign w_f_neg = -w_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_sf     <= w_f[FW-1];
        r3_fmag   <= w_f[FW-1] ? w_f_neg[FMW-1:0] : w_f[FMW-1:0];
        r3_center <= (r2_r2 == '0);
        r3_r2     <= r2_r2;
        r3_px     <= r2_px;
        r3_py     <= r2_py;
        r3_adx    <= r2_adx;
        r3_ady    <= r2_ady;
        r3_sdx    <= r2_sdx;
        r3_sdy    <= r2_sdy;
    end

    // stage 4: numerator magnitudes |d| * |r2 - K|
    logic [MW-1:0] w_ax4;
    logic [MW-1:0] w_ay4;
    logic [MW-1:0] w_f4;
    logic          r4_v;
    logic [MW-1:0] r4_magx;
    logic [MW-1:0] r4_magy;
    logic          r4_sx;
    logic          r4_sy;
    logic          r4_center;
    logic [RW-1:0] r4_r2;
    logic [CB-1:0] r4_px;
    logic [CB-1:0] r4_py;

    assign w_ax4 = MW'(r3_adx);
    assign w_ay4 = MW'(r3_ady);
    assign w_f4  = MW'(r3_fmag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_magx   <= w_ax4 * w_f4;
        r4_magy   <= w_ay4 * w_f4;
        r4_sx     <= r3_sdx ^ r3_sf;
        r4_sy     <= r3_sdy ^ r3_sf;
        r4_center <= r3_center;
        r4_r2     <= r3_r2;
        r4_px     <= r3_px;
        r4_py     <= r3_py;
    end

    // stage 5: rounding numerators 2|num| + r2, divisor 2*r2, quotient range check
    logic [NW-1:0] w_nx;
    logic [NW-1:0] w_ny;
    logic [DW-1:0] w_den;
    logic [CW-1:0] w_lim;
    logic          r5_v;
    logic [NW-1:0] r5_nx;
    logic [NW-1:0] r5_ny;
    logic [DW-1:0] r5_den;
    logic          r5_ovfx;
    logic          r5_ovfy;
    logic          r5_sx;
    logic          r5_sy;
    logic          r5_center;
    logic [CB-1:0] r5_px;
    logic [CB-1:0] r5_py;

    assign w_nx  = NW'({r4_magx, 1'b0}) + NW'(r4_r2);
    assign w_ny  = NW'({r4_magy, 1'b0}) + NW'(r4_r2);
    assign w_den = {r4_r2, 1'b0};
    assign w_lim = CW'(w_den) << QB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_nx     <= w_nx;
        r5_ny     <= w_ny;
        r5_den    <= w_den;
        r5_ovfx   <= (CW'(w_nx) >= w_lim);
        r5_ovfy   <= (CW'(w_ny) >= w_lim);
        r5_sx     <= r4_sx;
        r5_sy     <= r4_sy;
        r5_center <= r4_center;
        r5_px     <= r4_px;
        r5_py     <= r4_py;
    end

    // divider stages, with the per-request side data delayed alongside
    logic [QB-1:0]  w_qx;
    logic [QB-1:0]  w_qy;
    logic [SBW-1:0] r_sb  [0:QB-1];
    logic           r_sbv [0:QB-1];

    plsa_div #(
        .NUM_W (NW),
        .DEN_W (DW),
        .QUO_W (QB)
    ) u_div_x (
        .i_clk (i_clk),
        .i_num (r5_nx),
        .i_den (r5_den),
        .o_quo (w_qx)
    );

    plsa_div #(
        .NUM_W (NW),
        .DEN_W (DW),
        .QUO_W (QB)
    ) u_div_y (
        .i_clk (i_clk),
        .i_num (r5_ny),
        .i_den (r5_den),
        .o_quo (w_qy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QB; i++) begin
                r_sbv[i] <= 1'b0;
            end
        end else begin
            r_sbv[0] <= r5_v;
            for (int i = 1; i < QB; i++) begin
                r_sbv[i] <= r_sbv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= {r5_px, r5_py, r5_sx, r5_sy, r5_ovfx, r5_ovfy, r5_center};
        for (int i = 1; i < QB; i++) begin
            r_sb[i] <= r_sb[i-1];
        end
    end

    // final stage: source address, bounds test, output register
    logic [CB-1:0] w_px;
    logic [CB-1:0] w_py;
    logic          w_sx;
    logic          w_sy;
    logic          w_ovfx;
    logic          w_ovfy;
    logic          w_center;
    logic [SW-1:0] w_qxs;
    logic [SW-1:0] w_qys;
    logic [SW-1:0] w_sc;
    logic [SW-1:0] w_sr;
    logic          w_inside;
    logic          r_o_done;
    logic [CB-1:0] r_o_col;
    logic [CB-1:0] r_o_row;
    logic          r_o_inside;
    logic          r_o_center;

    assign {w_px, w_py, w_sx, w_sy, w_ovfx, w_ovfy, w_center} = r_sb[QB-1];
    assign w_qxs = SW'(w_qx);
    assign w_qys = SW'(w_qy);

    always_comb begin
        if (w_center) begin
            w_sc = SW'(w_px);
            w_sr = SW'(w_py);
        end else begin
            w_sc = SW'(r_center_x) + (w_sx ? -w_qxs : w_qxs);
            w_sr = SW'(r_center_y) + (w_sy ? w_qys : -w_qys);
        end
        w_inside = (w_center | ~(w_ovfx | w_ovfy))
                 & ~w_sc[SW-1] & ~w_sr[SW-1]
                 & (w_sc <= SW'(r_last_column))
                 & (w_sr <= SW'(r_last_row));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_done <= 1'b0;
        end else begin
            r_o_done <= r_sbv[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_col    <= w_inside ? w_sc[CB-1:0] : '0;
        r_o_row    <= w_inside ? w_sr[CB-1:0] : '0;
        r_o_inside <= w_inside;
        r_o_center <= w_center;
    end

    assign o_done          = r_o_done;
    assign o_source_column = r_o_col;
    assign o_source_row    = r_o_row;
    assign o_inside_res    = r_o_inside;
    assign o_at_center     = r_o_center;

endmodule

`default_nettype wire

// ----- design/plsa_chk.sv -----
// plsa_chk: port-level checks of point_lens_source_address, attached by bind
// uses plsa_pkg; binds to point_lens_source_address
`default_nettype none

module plsa_chk
    import plsa_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [COORD_BITS-1:0] i_pixel_column,
    input logic [COORD_BITS-1:0] i_pixel_row,
    input logic                  o_done,
    input logic [COORD_BITS-1:0] o_source_column,
    input logic [COORD_BITS-1:0] o_source_row,
    input logic                  o_inside_res,
    input logic                  o_at_center
);

    localparam int LAT = plsa_latency(COORD_BITS);

    // every result traces back to a request a fixed latency earlier
    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without a matching request");

    // a source outside the image reads as address zero
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_inside_res) |-> (o_source_column == '0 && o_source_row == '0))
        else $error("outside source with nonzero address");

    // at the lens center, when inside the image, the source is the pixel itself
    a_center_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_at_center && o_inside_res) |->
            (o_source_column == $past(i_pixel_column, LAT)
             && o_source_row == $past(i_pixel_row, LAT)))
        else $error("center pixel does not map to itself");

endmodule

bind point_lens_source_address plsa_chk #(
    .COORD_BITS (COORD_BITS)
) u_plsa_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_pixel_column  (i_pixel_column),
    .i_pixel_row     (i_pixel_row),
    .o_done          (o_done),
    .o_source_column (o_source_column),
    .o_source_row    (o_source_row),
    .o_inside_res    (o_inside_res),
    .o_at_center     (o_at_center)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
// tb_top: self-checking bench for point_lens_source_address, pixel requests plus apb register access
// predicts source addresses locally from a mirror of the lens registers, except on typed directed rows
// depends on plsa_pkg and the point_lens_source_address rtl
module tb_top;
    import plsa_pkg::*;

    localparam int CB        = COORD_BITS_DEF;
    localparam int COORD_MAX = (1 << CB) - 1;
    localparam int K_MAX     = (1 << K_BITS) - 1;
    localparam int N_PHASES  = 12;
    localparam int PHASE_REQ = 110;

    typedef struct packed {
        logic [CB-1:0] column;
        logic [CB-1:0] row;
        logic          in_image;
        logic          center;
    } t_lens_result;

    typedef struct packed {
        logic [CB-1:0] column;
        logic [CB-1:0] row;
        logic          typed;
        t_lens_result  want;
    } t_pixel_stim;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [CB-1:0]        i_pixel_column;
    logic [CB-1:0]        i_pixel_row;
    logic                 o_done;
    logic [CB-1:0]        o_source_column;
    logic [CB-1:0]        o_source_row;
    logic                 o_inside_res;
    logic                 o_at_center;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // register mirror
    logic [CB-1:0]     lens_cx;
    logic [CB-1:0]     lens_cy;
    logic [K_BITS-1:0] lens_k;
    logic [CB-1:0]     lens_last_col;
    logic [CB-1:0]     lens_last_row;

    t_lens_result pending_sources[$];
    t_pixel_stim  directed_rows[$];
    t_lens_result want_src;
    t_lens_result got_src;
    int           errors    = 0;
    int           n_results = 0;
    int           n_inside  = 0;
    int           n_center  = 0;

    point_lens_source_address #(
        .COORD_BITS(CB)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_pixel_column  (i_pixel_column),
        .i_pixel_row     (i_pixel_row),
        .o_done          (o_done),
        .o_source_column (o_source_column),
        .o_source_row    (o_source_row),
        .o_inside_res    (o_inside_res),
        .o_at_center     (o_at_center),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("%0t: timeout, %0d source addresses still pending", $time,
                 pending_sources.size());
        $display("Some tests failed");
        $finish;
    end

    // rounds num / den half away from zero, den > 0
    function automatic longint round_away(input longint num, input longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (2 * mag + den) / (2 * den);
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic t_lens_result source_of(input logic [CB-1:0] col,
                                               input logic [CB-1:0] row);
        longint px, py, cx, cy, k, lc, lr, dx, dy, r2, sc, sr;
        t_lens_result res;
        px = longint'(col);
        py = longint'(row);
        cx = longint'(lens_cx);
        cy = longint'(lens_cy);
        k  = longint'(lens_k);
        lc = longint'(lens_last_col);
        lr = longint'(lens_last_row);
        dx = px - cx;
        dy = cy - py;
        r2 = dx * dx + dy * dy;
        res.center = (r2 == 0);
        if (res.center) begin
            sc = px;
            sr = py;
        end else begin
            sc = cx + round_away(dx * (r2 - k), r2);
            sr = cy - round_away(dy * (r2 - k), r2);
        end
        res.in_image = (sc >= 0) && (sr >= 0) && (sc <= lc) && (sr <= lr);
        res.column   = res.in_image ? sc[CB-1:0] : '0;
        res.row      = res.in_image ? sr[CB-1:0] : '0;
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            got_src = {o_source_column, o_source_row, o_inside_res, o_at_center};
            n_results++;
            n_inside += got_src.in_image;
            n_center += got_src.center;
            if (pending_sources.size() == 0) begin
                $display("%0t: result with no request pending: col %0d row %0d in %0b ctr %0b",
                         $time, got_src.column, got_src.row, got_src.in_image,
                         got_src.center);
                errors++;
            end else begin
                want_src = pending_sources.pop_front();
                if (got_src.column !== want_src.column || got_src.row !== want_src.row ||
                    got_src.in_image !== want_src.in_image ||
                    got_src.center !== want_src.center)
                begin
                    $display("%0t: expected col %0d row %0d in %0b ctr %0b, got col %0d row %0d in %0b ctr %0b",
                             $time, want_src.column, want_src.row, want_src.in_image,
                             want_src.center, got_src.column, got_src.row, got_src.in_image,
                             got_src.center);
                    errors++;
                end
            end
        end
    end

    task automatic add_row(input int col, input int row, input bit typed, input int ecol,
                           input int erow, input bit ein, input bit ectr);
        t_pixel_stim s;
        s.column        = CB'(col);
        s.row           = CB'(row);
        s.typed         = typed;
        s.want.column   = CB'(ecol);
        s.want.row      = CB'(erow);
        s.want.in_image = ein;
        s.want.center   = ectr;
        directed_rows.push_back(s);
    endtask

    task automatic issue_pixel(input logic [CB-1:0] col, input logic [CB-1:0] row,
                               input int idle_pct, input t_lens_result want);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start          <= 1'b0;
            i_pixel_column <= CB'($urandom_range(0, COORD_MAX));
            i_pixel_row    <= CB'($urandom_range(0, COORD_MAX));
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_pixel_column <= col;
        i_pixel_row    <= row;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_sources.push_back(want);
    endtask

    task automatic drain;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_sources.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_BITS-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER_X:    lens_cx       = value[CB-1:0];
            REG_CENTER_Y:    lens_cy       = value[CB-1:0];
            REG_LENS_K:      lens_k        = value[K_BITS-1:0];
            REG_LAST_COLUMN: lens_last_col = value[CB-1:0];
            REG_LAST_ROW:    lens_last_row = value[CB-1:0];
            default: ;
        endcase
    endtask

    task automatic read_reg(input t_reg_idx idx, input logic [DATA_BITS-1:0] want);
        logic [DATA_BITS-1:0] seen;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        seen = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== want) begin
            $display("%0t: register %0d read %0d, expected %0d", $time, idx, seen, want);
            errors++;
        end
    endtask

    task automatic check_regs;
        read_reg(REG_CENTER_X, DATA_BITS'(lens_cx));
        read_reg(REG_CENTER_Y, DATA_BITS'(lens_cy));
        read_reg(REG_LENS_K, DATA_BITS'(lens_k));
        read_reg(REG_LAST_COLUMN, DATA_BITS'(lens_last_col));
        read_reg(REG_LAST_ROW, DATA_BITS'(lens_last_row));
    endtask

    // optionally sets bits above the register width, which must be dropped
    function automatic logic [DATA_BITS-1:0] dirty(input int v, input int width, input bit junk);
        logic [DATA_BITS-1:0] w;
        w = v;
        if (junk)
            w = w | ($urandom() << width);
        return w;
    endfunction

    task automatic program_lens(input int cx, input int cy, input int k, input int lc,
                                input int lr, input bit junk);
        write_reg(REG_CENTER_X, dirty(cx, CB, junk));
        write_reg(REG_CENTER_Y, dirty(cy, CB, junk));
        write_reg(REG_LENS_K, dirty(k, K_BITS, junk));
        write_reg(REG_LAST_COLUMN, dirty(lc, CB, junk));
        write_reg(REG_LAST_ROW, dirty(lr, CB, junk));
        check_regs();
    endtask

    initial begin
        int            idle_pct;
        int            rad;
        int            pick;
        logic [CB-1:0] col;
        logic [CB-1:0] row;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_pixel_column = '0;
        i_pixel_row    = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        lens_cx        = CB'(CENTER_X_RST);
        lens_cy        = CB'(CENTER_Y_RST);
        lens_k         = K_BITS'(LENS_K_RST);
        lens_last_col  = CB'(LAST_COLUMN_RST);
        lens_last_row  = CB'(LAST_ROW_RST);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_regs();

        // default lens: center (45,50), K 100, 100x100 image
        add_row(45, 50, 1, 45, 50, 1, 1);        // lens center
        add_row(55, 50, 1, 45, 50, 1, 0);        // on the einstein ring
        add_row(45, 40, 1, 45, 50, 1, 0);
        add_row(46, 50, 1, 0, 0, 0, 0);          // strong lens throws source off image
        add_row(45, 51, 1, 0, 0, 0, 0);
        add_row(COORD_MAX, COORD_MAX, 1, 0, 0, 0, 0);
        add_row(COORD_MAX, 0, 1, 0, 0, 0, 0);
        add_row(0, COORD_MAX, 1, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 0);
        add_row(53, 50, 0, 0, 0, 0, 0);          // half-way rounding, both signs
        add_row(37, 50, 0, 0, 0, 0, 0);
        add_row(45, 42, 0, 0, 0, 0, 0);
        add_row(45, 58, 0, 0, 0, 0, 0);
        add_row(50, 50, 0, 0, 0, 0, 0);
        add_row(60, 50, 0, 0, 0, 0, 0);
        add_row(99, 99, 0, 0, 0, 0, 0);
        add_row(0, 50, 0, 0, 0, 0, 0);
        add_row(45, 0, 0, 0, 0, 0, 0);
        add_row(30, 70, 0, 0, 0, 0, 0);
        foreach (directed_rows[i])
            issue_pixel(directed_rows[i].column, directed_rows[i].row, 0,
                        directed_rows[i].typed ? directed_rows[i].want :
                        source_of(directed_rows[i].column, directed_rows[i].row));
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: program_lens(0, 0, 0, COORD_MAX, COORD_MAX, 0);
                1: program_lens(COORD_MAX, COORD_MAX, K_MAX, COORD_MAX, COORD_MAX, 1);
                2: program_lens(COORD_MAX, COORD_MAX, 1, 0, 0, 0);
                3: program_lens(0, COORD_MAX, K_MAX, COORD_MAX / 2, COORD_MAX, 1);
                default: begin
                    program_lens($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, K_MAX) :
                                                               $urandom_range(0, 4000),
                                 $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                 $urandom_range(0, 1));
                end
            endcase
            case (p % 4)
                1:       idle_pct = 85;
                3:       idle_pct = 35;
                default: idle_pct = 0;
            endcase
            rad = $urandom_range(4, 300);
            for (int n = 0; n < PHASE_REQ; n++) begin
                pick = $urandom_range(0, 15);
                if (pick == 0) begin
                    col = lens_cx;
                    row = lens_cy;
                end else if (pick < 10) begin
                    col = CB'(int'(lens_cx) + int'($urandom_range(0, 2 * rad)) - rad);
                    row = CB'(int'(lens_cy) + int'($urandom_range(0, 2 * rad)) - rad);
                end else begin
                    col = CB'($urandom_range(0, COORD_MAX));
                    row = CB'($urandom_range(0, COORD_MAX));
                end
                issue_pixel(col, row, idle_pct, source_of(col, row));
            end
            drain();
        end

        repeat (plsa_latency(CB) + 4) @(posedge i_clk);
        $display("checked %0d source addresses over %0d lens settings plus the reset one",
                 n_results, N_PHASES);
        $display("%0d sources fell inside the image, %0d requests hit the lens center",
                 n_inside, n_center);
        if (errors == 0 && pending_sources.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/plsa_pkg.sv
design/plsa_div.sv
design/point_lens_source_address.sv
design/plsa_chk.sv
dv/tb_top.sv
